[src/rbdq_pkg.sv]
// Shared types and constants for the ring buffer deque unit.
package rbdq_pkg;

	localparam int WORD_W   = 32;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

	// One operation travelling along the row of cells.
	typedef struct packed {
		logic                       valid;
		logic                       wr;
		logic                       rd;
		logic [STATUS_W-1:0]        status;
		logic signed [WORD_W-1:0]   word;
	} rbdq_op_t;

endpackage

[src/rbdq_cell.sv]
// One storage cell of the deque: holds a slot and passes operations to its neighbour.
module rbdq_cell #(
	parameter int CELL_IDX = 0,
	parameter int AW       = 4,
	parameter int CW       = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rbdq_pkg::rbdq_op_t  in_op,
	input  logic [AW-1:0]       in_addr,
	input  logic [CW-1:0]       in_occ,
	output rbdq_pkg::rbdq_op_t  out_op,
	output logic [AW-1:0]       out_addr,
	output logic [CW-1:0]       out_occ
);

	logic signed [rbdq_pkg::WORD_W-1:0] slot_q;
	rbdq_pkg::rbdq_op_t                 op_q;
	rbdq_pkg::rbdq_op_t                 op_d;
	logic [AW-1:0]                      addr_q;
	logic [CW-1:0]                      occ_q;
	logic                               hit;

	assign hit = in_op.valid && (in_addr == AW'(CELL_IDX));

	always_ff @(posedge clk) begin
		if (en && hit && in_op.wr) begin
			slot_q <= in_op.word;
		end
	end

	// A push leaves its word behind and reports zero; a read picks up the slot.
	always_comb begin
		op_d = in_op;
		if (hit && in_op.wr) begin
			op_d.word = '0;
		end else if (hit && in_op.rd) begin
			op_d.word = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
		end else if (en) begin
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_q <= in_addr;
			occ_q  <= in_occ;
		end
	end

	assign out_op   = op_q;
	assign out_addr = addr_q;
	assign out_occ  = occ_q;

endmodule

[src/ring_buffer_deque_unit.sv]
// Top level of the ring buffer deque unit: pointer control and the row of slot cells.
// Every accepted word walks the whole row of cells, writing or reading its slot as it
// passes that cell, and is registered in each cell on its way to the output.
// Throughput: one word per cycle while the output is taken; the first cell takes a new
// word while a result waits at the output only if it holds none itself.
// Reset: head, tail and count clear, capacity returns to DEPTH; slots are undefined until written.
module ring_buffer_deque_unit #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int OW = ((rbdq_pkg::WORD_W + CW + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CW-1:0]                 cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rbdq_pkg::WORD_W-1:0]   s_tdata,   // value
	input  logic [rbdq_pkg::KIND_W-1:0]   s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OW-1:0]                 m_tdata,   // data, occupancy, zero fill
	output logic [rbdq_pkg::STATUS_W-1:0] m_tuser    // status
);

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] cap_q;
	logic          accept, advance, en0;

	rbdq_pkg::rbdq_op_t op_head;
	logic [AW-1:0]      addr_head;
	logic [CW-1:0]      occ_head;

	rbdq_pkg::rbdq_op_t op_c   [0:DEPTH];
	logic [AW-1:0]      addr_c [0:DEPTH];
	logic [CW-1:0]      occ_c  [0:DEPTH];

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i, input logic [CW-1:0] cap);
		return (CW'(i) >= cap - CW'(1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i,
			input logic [CW-1:0] cap);
		return (i == '0) ? AW'(cap - CW'(1)) : i - AW'(1);
	endfunction

	assign cfg_ready = 1'b1;

	// Out-of-range capacities are folded into the legal range when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data == '0) begin
				cap_q <= CW'(1);
			end else if (cfg_data > CW'(DEPTH)) begin
				cap_q <= CW'(DEPTH);
			end else begin
				cap_q <= cfg_data;
			end
		end
	end

	assign advance  = !op_c[DEPTH].valid || m_tready;
	assign en0      = advance || !op_c[1].valid;
	assign s_tready = en0;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		head_d         = head_q;
		tail_d         = tail_q;
		count_d        = count_q;
		op_head.valid  = accept;
		op_head.wr     = 1'b0;
		op_head.rd     = 1'b0;
		op_head.status = rbdq_pkg::ST_DONE;
		op_head.word   = '0;
		addr_head      = '0;
		case (s_tuser) inside
			rbdq_pkg::KIND_PUSH_REAR, rbdq_pkg::KIND_PUSH_FRONT: begin
				if (count_q >= cap_q) begin
					op_head.status = rbdq_pkg::ST_FULL;
				end else begin
					op_head.wr   = 1'b1;
					op_head.word = s_tdata;
					if (count_q == '0) begin
						head_d = '0;
						tail_d = '0;
					end else if (s_tuser == rbdq_pkg::KIND_PUSH_REAR) begin
						tail_d    = step_up(tail_q, cap_q);
						addr_head = tail_d;
					end else begin
						head_d    = step_down(head_q, cap_q);
						addr_head = head_d;
					end
					count_d = count_q + CW'(1);
				end
			end
			rbdq_pkg::KIND_POP_FRONT, rbdq_pkg::KIND_POP_REAR,
			rbdq_pkg::KIND_PEEK_FRONT, rbdq_pkg::KIND_PEEK_REAR: begin
				if (count_q == '0) begin
					op_head.status = rbdq_pkg::ST_EMPTY;
					op_head.word   = rbdq_pkg::WORD_MIN;
				end else begin
					op_head.rd = 1'b1;
					if (s_tuser == rbdq_pkg::KIND_POP_FRONT
							|| s_tuser == rbdq_pkg::KIND_PEEK_FRONT) begin
						addr_head = head_q;
					end else begin
						addr_head = tail_q;
					end
					if (s_tuser == rbdq_pkg::KIND_POP_FRONT
							|| s_tuser == rbdq_pkg::KIND_POP_REAR) begin
						count_d = count_q - CW'(1);
						if (count_d == '0) begin
							head_d = '0;
							tail_d = '0;
						end else if (s_tuser == rbdq_pkg::KIND_POP_FRONT) begin
							head_d = step_up(head_q, cap_q);
						end else begin
							tail_d = step_down(tail_q, cap_q);
						end
					end
				end
			end
			default: begin
			end
		endcase
		occ_head = count_d;
	end

	assign op_c[0]   = op_head;
	assign addr_c[0] = addr_head;
	assign occ_c[0]  = occ_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rbdq_cell #(
			.CELL_IDX (i),
			.AW       (AW),
			.CW       (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       ((i == 0) ? en0 : advance),
			.in_op    (op_c[i]),
			.in_addr  (addr_c[i]),
			.in_occ   (occ_c[i]),
			.out_op   (op_c[i+1]),
			.out_addr (addr_c[i+1]),
			.out_occ  (occ_c[i+1])
		);
	end

	assign m_tvalid = op_c[DEPTH].valid;
	assign m_tdata  = OW'({occ_c[DEPTH], op_c[DEPTH].word});
	assign m_tuser  = op_c[DEPTH].status;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count exceeds the store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> (head_q == '0 && tail_q == '0))
		else $error("pointers not parked while the deque is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> op_c[1].valid)
		else $error("accepted word did not enter the first cell");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == rbdq_pkg::ST_FULL) |-> m_tdata[rbdq_pkg::WORD_W-1:0] == '0)
		else $error("dropped push reported non-zero data");

endmodule

[tb/ring_buffer_deque_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ring buffer deque unit, with a behavioural deque as predictor.
module ring_buffer_deque_unit_test;

	localparam int DEPTH        = 16;
	localparam int CAP_W        = 5;
	localparam int OUT_W        = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int IDLE_PCT     = 24;

	// The two kind codes that name no operation.
	localparam logic [rbdq_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [rbdq_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

	typedef struct {
		logic signed [rbdq_pkg::WORD_W-1:0] data;
		logic [rbdq_pkg::STATUS_W-1:0]      status;
		logic [CAP_W-1:0]                   occupancy;
	} deque_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CAP_W-1:0]              cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [rbdq_pkg::WORD_W-1:0]   s_tdata;   // value
	logic [rbdq_pkg::KIND_W-1:0]   s_tuser;   // kind
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [OUT_W-1:0]              m_tdata;   // data, occupancy, zero fill
	logic [rbdq_pkg::STATUS_W-1:0] m_tuser;   // status

	// Predicted contents of the deque.
	logic signed [rbdq_pkg::WORD_W-1:0] deque_slots [DEPTH];
	int                                 front_idx;
	int                                 rear_idx;
	int                                 held_count;
	logic [CAP_W-1:0]                   capacity_reg;

	deque_result_t pending_results [$];
	int            fail_count = 0;
	int            cycles_run = 0;
	int            idle_pct = IDLE_PCT;

	ring_buffer_deque_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int wrap_up(input int idx, input int cap);
		return (idx >= cap - 1) ? 0 : idx + 1;
	endfunction

	function automatic int wrap_down(input int idx, input int cap);
		return (idx == 0) ? cap - 1 : idx - 1;
	endfunction

	// Applies one operation to the predicted deque and returns the word it should produce.
	function automatic deque_result_t apply_deque_op(input logic [rbdq_pkg::KIND_W-1:0] kind,
			input logic signed [rbdq_pkg::WORD_W-1:0] value);
		deque_result_t r;
		int            cap;
		logic          at_front;
		cap = capacity_reg;
		if (cap == 0) cap = 1;
		if (cap > DEPTH) cap = DEPTH;
		r.data   = '0;
		r.status = rbdq_pkg::ST_DONE;
		case (kind)
			rbdq_pkg::KIND_PUSH_REAR, rbdq_pkg::KIND_PUSH_FRONT: begin
				if (held_count >= cap) begin
					r.status = rbdq_pkg::ST_FULL;
				end else begin
					if (held_count == 0) begin
						front_idx      = 0;
						rear_idx       = 0;
						deque_slots[0] = value;
					end else if (kind == rbdq_pkg::KIND_PUSH_REAR) begin
						rear_idx              = wrap_up(rear_idx, cap);
						deque_slots[rear_idx] = value;
					end else begin
						front_idx              = wrap_down(front_idx, cap);
						deque_slots[front_idx] = value;
					end
					held_count++;
				end
			end
			rbdq_pkg::KIND_POP_FRONT, rbdq_pkg::KIND_POP_REAR,
			rbdq_pkg::KIND_PEEK_FRONT, rbdq_pkg::KIND_PEEK_REAR: begin
				if (held_count == 0) begin
					r.data   = rbdq_pkg::WORD_MIN;
					r.status = rbdq_pkg::ST_EMPTY;
				end else begin
					at_front = (kind == rbdq_pkg::KIND_POP_FRONT)
						|| (kind == rbdq_pkg::KIND_PEEK_FRONT);
					r.data   = deque_slots[at_front ? front_idx : rear_idx];
					if (kind == rbdq_pkg::KIND_POP_FRONT
							|| kind == rbdq_pkg::KIND_POP_REAR) begin
						held_count--;
						if (held_count == 0) begin
							front_idx = 0;
							rear_idx  = 0;
						end else if (at_front) begin
							front_idx = wrap_up(front_idx, cap);
						end else begin
							rear_idx = wrap_down(rear_idx, cap);
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.occupancy = held_count[CAP_W-1:0];
		return r;
	endfunction

	function automatic logic signed [rbdq_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return rbdq_pkg::WORD_MIN;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [rbdq_pkg::KIND_W-1:0] kind,
			input logic signed [rbdq_pkg::WORD_W-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_deque_op(kind, value));
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		capacity_reg = cap;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic empty_deque();
		while (held_count != 0)
			send_word($urandom_range(1) ? rbdq_pkg::KIND_POP_FRONT : rbdq_pkg::KIND_POP_REAR,
				pick_word());
	endtask

	task automatic test_empty_reads();
		send_word(rbdq_pkg::KIND_POP_FRONT, pick_word());
		send_word(rbdq_pkg::KIND_POP_REAR, pick_word());
		send_word(rbdq_pkg::KIND_PEEK_FRONT, pick_word());
		send_word(rbdq_pkg::KIND_PEEK_REAR, pick_word());
		send_word(KIND_SPARE_A, 32'sh7FFF_FFFF);
		send_word(KIND_SPARE_B, -32'sd1);
	endtask

	task automatic test_word_extremes();
		send_word(rbdq_pkg::KIND_PUSH_REAR, rbdq_pkg::WORD_MIN);
		send_word(rbdq_pkg::KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_word(rbdq_pkg::KIND_PUSH_REAR, '0);
		send_word(rbdq_pkg::KIND_PUSH_FRONT, -32'sd1);
		send_word(rbdq_pkg::KIND_PEEK_FRONT, '0);
		send_word(rbdq_pkg::KIND_PEEK_REAR, '0);
		send_word(rbdq_pkg::KIND_POP_REAR, '0);
		send_word(rbdq_pkg::KIND_POP_FRONT, '0);
		send_word(rbdq_pkg::KIND_POP_FRONT, '0);
		send_word(rbdq_pkg::KIND_POP_REAR, '0);
	endtask

	// A capacity of zero behaves as a single slot.
	task automatic test_single_slot();
		set_capacity(5'd0);
		send_word(rbdq_pkg::KIND_PUSH_REAR, 32'sh5555_5555);
		send_word(rbdq_pkg::KIND_PUSH_FRONT, 32'shAAAA_AAAA);
		send_word(rbdq_pkg::KIND_PEEK_FRONT, '0);
		send_word(rbdq_pkg::KIND_POP_REAR, '0);
	endtask

	// Grows the capacity while words are held, with the contents not wrapped.
	task automatic test_capacity_growth();
		set_capacity(5'd2);
		send_word(rbdq_pkg::KIND_PUSH_REAR, 32'sh1234_5678);
		send_word(rbdq_pkg::KIND_PUSH_REAR, 32'sh0F0F_0F0F);
		send_word(rbdq_pkg::KIND_PUSH_FRONT, 32'sh7777_7777);
		set_capacity(5'd5);
		send_word(rbdq_pkg::KIND_PUSH_FRONT, -32'sd77);
		send_word(rbdq_pkg::KIND_PUSH_REAR, 32'sh7654_3210);
		repeat (4) send_word(rbdq_pkg::KIND_POP_FRONT, '0);
	endtask

	task automatic random_phase(input int n_items);
		int                          push_pct;
		logic [rbdq_pkg::KIND_W-1:0] kind;
		push_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			// Bursts lean towards filling or emptying so that both ends get reached.
			if (i % 20 == 0)
				push_pct = 15 + 35 * $urandom_range(2);
			if ($urandom_range(99) < 4) begin
				kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
			end else if ($urandom_range(99) < push_pct) begin
				kind = $urandom_range(1) ? rbdq_pkg::KIND_PUSH_REAR
					: rbdq_pkg::KIND_PUSH_FRONT;
			end else begin
				case ($urandom_range(3))
					0: kind = rbdq_pkg::KIND_POP_FRONT;
					1: kind = rbdq_pkg::KIND_POP_REAR;
					2: kind = rbdq_pkg::KIND_PEEK_FRONT;
					default: kind = rbdq_pkg::KIND_PEEK_REAR;
				endcase
			end
			send_word(kind, pick_word());
		end
	endtask

	task automatic test_random_capacities();
		logic [CAP_W-1:0] caps [11];
		caps = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd7, 5'd2, 5'd16, 5'd12, 5'd0, 5'd20, 5'd5};
		foreach (caps[p]) begin
			empty_deque();
			set_capacity(caps[p]);
			idle_pct = (p == 6) ? 0 : IDLE_PCT;
			random_phase(90);
		end
		idle_pct = IDLE_PCT;
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= idle_pct);

	always @(posedge clk) begin : result_check
		deque_result_t                      want;
		logic signed [rbdq_pkg::WORD_W-1:0] got_data;
		logic [CAP_W-1:0]                   got_occ;
		cycles_run++;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles_run,
				pending_results.size());
			$display("TEST FAILED");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			got_data = m_tdata[rbdq_pkg::WORD_W-1:0];
			got_occ  = m_tdata[rbdq_pkg::WORD_W +: CAP_W];
			if (pending_results.size() == 0) begin
				if (fail_count < REPORT_LIMIT)
					$display("unexpected word: data %0d status %0d occupancy %0d",
						got_data, m_tuser, got_occ);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got_data !== want.data || m_tuser !== want.status ||
						got_occ !== want.occupancy) begin
					if (fail_count < REPORT_LIMIT) begin
						$write("mismatch: expected data %0d status %0d occupancy %0d",
							want.data, want.status, want.occupancy);
						$display(", got data %0d status %0d occupancy %0d",
							got_data, m_tuser, got_occ);
					end
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		foreach (deque_slots[i]) deque_slots[i] = '0;
		front_idx    = 0;
		rear_idx     = 0;
		held_count   = 0;
		capacity_reg = 5'd16;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_reads();
		test_word_extremes();
		test_single_slot();
		test_capacity_growth();
		test_random_capacities();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// Any stray word would still be inside the row of cells for this long.
		repeat (DEPTH + 4) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
